FILE: hw/rtl/sha256_block_compression_assert.svh
// Assertion macros for the SHA-256 block compression engine.
// Each macro expects signals named clk and rst in the including scope.
`ifndef SHA256_BLOCK_COMPRESSION_ASSERT_SVH
`define SHA256_BLOCK_COMPRESSION_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Consequent holds in the same cycle as the antecedent.
`define SHA_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define SHA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define SHA_ASSERT_SAME(label, ante, cons, msg)
`define SHA_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

FILE: hw/rtl/sha_pkg.sv
package sha_pkg;

  // Word and block geometry.
  localparam int unsigned WORD_W      = 32;
  localparam int unsigned BLOCK_WORDS = 16;
  localparam int unsigned HASH_WORDS  = 8;
  localparam int unsigned NUM_ROUNDS  = 64;

  typedef logic [WORD_W-1:0] word_t;

  // Round constants.
  localparam word_t ROUND_K [NUM_ROUNDS] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // Standard initial hash value.
  localparam word_t INIT_HASH [HASH_WORDS] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // Message schedule sigma functions.
  function automatic word_t small_s0(word_t x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic word_t small_s1(word_t x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

  // Round sigma functions.
  function automatic word_t big_s0(word_t x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic word_t big_s1(word_t x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic word_t choose(word_t x, word_t y, word_t z);
    return (x & y) ^ (~x & z);
  endfunction

  function automatic word_t majority(word_t x, word_t y, word_t z);
    return (x & y) ^ (x & z) ^ (y & z);
  endfunction

endpackage

FILE: hw/rtl/sha_if.sv
// Message word channel.
interface sha_msg_if import sha_pkg::*; ();
  logic  valid;
  logic  ready;
  word_t msg_word;
  logic  first_word;
  logic  final_block;

  modport source (output valid, msg_word, first_word, final_block, input ready);
  modport sink   (input valid, msg_word, first_word, final_block, output ready);
endinterface

// Digest word channel.
interface sha_dig_if import sha_pkg::*; ();
  logic       valid;
  logic       ready;
  word_t      digest_word;
  logic [2:0] word_index;
  logic       last;

  modport source (output valid, digest_word, word_index, last, input ready);
  modport sink   (input valid, digest_word, word_index, last, output ready);
endinterface

FILE: hw/rtl/sha256_block_compression.sv
// Message words are taken one per cycle while idle; the sixteenth word of a block
// starts a compression that keeps the input stalled while it reads the chaining
// value from its memory, runs 64 rounds, then reads, adds and writes it back.
// A final block is followed by the digest words, read from the chaining memory.
// Synchronous reset returns to idle with an empty block and the initial hash selected.
module sha256_block_compression import sha_pkg::*; (
  input logic      clk,
  input logic      rst,
  sha_msg_if.sink  msg,
  sha_dig_if.source dig
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_LOAD   = 5'b00010,
    S_ROUND  = 5'b00100,
    S_UPDATE = 5'b01000,
    S_EMIT   = 5'b10000
  } state_t;

  state_t     state, state_next;
  logic [3:0] word_count;
  logic [3:0] step;
  logic [5:0] round_idx;
  logic       h_init;
  logic       final_pend;
  logic       emit_rd;
  logic [2:0] rd_idx;
  logic       out_valid;
  word_t      out_word;
  logic [2:0] out_idx;

  word_t sched [BLOCK_WORDS];
  word_t v [HASH_WORDS];

  // Chaining value memory.
  word_t      chain_mem [HASH_WORDS];
  word_t      mem_rdata;
  logic       mem_we;
  logic [2:0] mem_addr_rd;
  logic [2:0] mem_addr_wr;
  word_t      mem_wdata;

  logic       msg_fire;
  logic       dig_fire;
  logic [3:0] count_base;
  logic       block_done;
  logic       last_round;
  logic [2:0] prev_idx;
  word_t      chain_old;
  logic       emit_issue;
  word_t      t1, t2, w_new;

  // Handshake and block counting.
  assign msg.ready  = (state == S_IDLE);
  assign msg_fire   = msg.valid && msg.ready;
  assign dig_fire   = dig.valid && dig.ready;
  assign count_base = msg.first_word ? 4'd0 : word_count;
  assign block_done = (count_base == 4'(BLOCK_WORDS - 1));
  assign last_round = (round_idx == 6'(NUM_ROUNDS - 1));

  assign dig.valid       = out_valid;
  assign dig.digest_word = out_word;
  assign dig.word_index  = out_idx;
  assign dig.last        = (out_idx == 3'(HASH_WORDS - 1));

  // Memory access: read at the step counter, write one step behind it.
  assign prev_idx    = 3'(step - 4'd1);
  assign chain_old   = h_init ? INIT_HASH[prev_idx] : mem_rdata;
  assign mem_addr_rd = step[2:0];
  assign mem_addr_wr = prev_idx;
  assign mem_we      = (state == S_UPDATE) && (step != 4'd0);
  assign mem_wdata   = chain_old + v[prev_idx];

  assign emit_issue = (state == S_EMIT) && !emit_rd && !step[3] && (!out_valid || dig.ready);

  // Round function and schedule expansion.
  always_comb begin
    t1 = v[7] + big_s1(v[4]) + choose(v[4], v[5], v[6]) + ROUND_K[round_idx] + sched[0];
    t2 = big_s0(v[0]) + majority(v[0], v[1], v[2]);
    w_new = small_s1(sched[14]) + sched[9] + small_s0(sched[1]) + sched[0];
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      chain_mem[mem_addr_wr] <= mem_wdata;
    end
    mem_rdata <= chain_mem[mem_addr_rd];
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (msg_fire && block_done) state_next = S_LOAD;
      end
      S_LOAD: begin
        if (step == 4'(HASH_WORDS)) state_next = S_ROUND;
      end
      S_ROUND: begin
        if (last_round) state_next = S_UPDATE;
      end
      S_UPDATE: begin
        if (step == 4'(HASH_WORDS)) state_next = final_pend ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        if (dig_fire && dig.last) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      word_count <= 4'd0;
      step       <= 4'd0;
      round_idx  <= 6'd0;
      h_init     <= 1'b1;
      final_pend <= 1'b0;
      emit_rd    <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        S_IDLE: begin
          if (msg_fire) begin
            word_count <= count_base + 4'd1;
            if (msg.first_word) h_init <= 1'b1;
            if (block_done) begin
              final_pend <= msg.final_block;
              step       <= 4'd0;
            end
          end
        end
        S_LOAD: begin
          if (step == 4'(HASH_WORDS)) begin
            step      <= 4'd0;
            round_idx <= 6'd0;
          end else begin
            step <= step + 4'd1;
          end
        end
        S_ROUND: begin
          round_idx <= round_idx + 6'd1;
          if (last_round) step <= 4'd0;
        end
        S_UPDATE: begin
          if (step == 4'(HASH_WORDS)) begin
            step   <= 4'd0;
            h_init <= 1'b0;
          end else begin
            step <= step + 4'd1;
          end
        end
        S_EMIT: begin
          if (emit_issue) step <= step + 4'd1;
        end
        default: ;
      endcase

      // One digest read in flight at a time; the output register is free when it lands.
      emit_rd <= emit_issue;
      if (emit_rd) begin
        out_valid <= 1'b1;
      end else if (dig_fire) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (emit_issue) rd_idx <= step[2:0];
    if (emit_rd) begin
      out_word <= mem_rdata;
      out_idx  <= rd_idx;
    end

    if (state == S_IDLE && msg_fire) begin
      for (int i = 0; i < BLOCK_WORDS - 1; i++) sched[i] <= sched[i+1];
      sched[BLOCK_WORDS-1] <= msg.msg_word;
    end

    if (state == S_LOAD && step != 4'd0) begin
      v[prev_idx] <= chain_old;
    end

    if (state == S_ROUND) begin
      for (int i = 0; i < BLOCK_WORDS - 1; i++) sched[i] <= sched[i+1];
      sched[BLOCK_WORDS-1] <= w_new;
      v[7] <= v[6];
      v[6] <= v[5];
      v[5] <= v[4];
      v[4] <= v[3] + t1;
      v[3] <= v[2];
      v[2] <= v[1];
      v[1] <= v[0];
      v[0] <= t1 + t2;
    end
  end

  // Checks on sequencing.
  `include "sha256_block_compression_assert.svh"

  `SHA_ASSERT_SAME(a_out_only_emit, dig.valid, state == S_EMIT, "digest outside emit phase")
  `SHA_ASSERT_NEXT(a_block_starts, msg_fire && block_done, state == S_LOAD, "block did not start")
  `SHA_ASSERT_NEXT(a_rounds_end, state == S_ROUND && last_round, state == S_UPDATE, "rounds overran")
  `SHA_ASSERT_NEXT(a_last_drains, dig_fire && dig.last, !dig.valid && state == S_IDLE, "digest overran")

endmodule
